@@ rtl/upq_pkg.sv @@
`default_nettype none

package upq_pkg;

    localparam int KEY_W        = 16;
    localparam int PRIO_W       = 32;
    localparam int CAPACITY_DEF = 32;

    // command codes
    localparam logic [1:0] CMD_ENQ      = 2'd0;
    localparam logic [1:0] CMD_DELMIN   = 2'd1;
    localparam logic [1:0] CMD_CONTAINS = 2'd2;
    localparam logic [1:0] CMD_UPDATE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;    // latch request fields
        logic start;     // init scan, do enqueue, set base status
        logic step;      // advance the scan by one entry
        logic upd_wr;    // rewrite matched entry
        logic last_rd;   // read last entry
        logic move;      // move last entry into freed slot
        logic load_out;  // load result register
    } upq_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       count_zero;
        logic       scan_done;
        logic       hit;
    } upq_stat_t;

endpackage

`default_nettype wire

@@ rtl/unsorted_priority_queue.sv @@
`default_nettype none
// enqueue and empty-queue commands skip the scan; contains / update-priority stop at a key match
// or the last entry; delete-min scans all entries, then moves the last entry into the freed slot
// one request in flight; entries are read through a single registered ram port, one per cycle
// next request taken while a result waits
// reset (asynchronous, active low) empties the queue; the entry ram itself is not cleared

module unsorted_priority_queue #(
    parameter int CAPACITY = upq_pkg::CAPACITY_DEF,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    command,
    input  wire logic [upq_pkg::KEY_W-1:0]     item_key,
    input  wire logic [upq_pkg::PRIO_W-1:0]    item_priority,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [upq_pkg::KEY_W-1:0]     out_key,
    output logic      [upq_pkg::PRIO_W-1:0]    out_priority,
    output logic                               key_found,
    output logic      [1:0]                    status,
    output logic      [CW-1:0]                 entries_held,
    output logic                               queue_empty
);

    // command strobes from the sequencer, scan status back from the datapath
    upq_pkg::upq_ctrl_t ctrl;
    upq_pkg::upq_stat_t stat;

    // sequencer: idle, dispatch, scan, fetch last, move, hand off result
    upq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // entry ram, count, scan counters, running minimum and result register
    upq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (command),
        .item_key      (item_key),
        .item_priority (item_priority),
        .out_key       (out_key),
        .out_priority  (out_priority),
        .key_found     (key_found),
        .status        (status),
        .entries_held  (entries_held),
        .queue_empty   (queue_empty)
    );

endmodule

`default_nettype wire

@@ rtl/upq_ram.sv @@
`default_nettype none

module upq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/upq_datapath.sv @@
`default_nettype none

module upq_datapath #(
    parameter int CAPACITY = upq_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire upq_pkg::upq_ctrl_t            ctrl,
    output upq_pkg::upq_stat_t                 stat,
    input  wire logic [1:0]                    command,
    input  wire logic [upq_pkg::KEY_W-1:0]     item_key,
    input  wire logic [upq_pkg::PRIO_W-1:0]    item_priority,
    output logic      [upq_pkg::KEY_W-1:0]     out_key,
    output logic      [upq_pkg::PRIO_W-1:0]    out_priority,
    output logic                               key_found,
    output logic      [1:0]                    status,
    output logic      [CW-1:0]                 entries_held,
    output logic                               queue_empty
);

    localparam int KW = upq_pkg::KEY_W;
    localparam int PW = upq_pkg::PRIO_W;
    localparam int EW = KW + PW;

    logic [1:0]    cmd_reg;
    logic [KW-1:0] key_reg;
    logic [PW-1:0] prio_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [AW-1:0] cmp_reg, cmp_next;
    logic          pend_reg, pend_next;
    logic          have_best_reg, have_best_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    logic [KW-1:0] best_key_reg, best_key_next;
    logic [PW-1:0] best_prio_reg, best_prio_next;
    logic          found_reg, found_next;
    logic [1:0]    res_st_reg, res_st_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;
    logic [KW-1:0] rd_key;
    logic [PW-1:0] rd_prio;

    logic          is_find;
    logic          full;
    logic          enq_ok;
    logic          issue;
    logic          hit;
    logic          at_last;
    logic [CW-1:0] last_pos;

    upq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[EW-1:PW];
    assign rd_prio  = ram_rdata[PW-1:0];
    assign is_find  = (cmd_reg == upq_pkg::CMD_CONTAINS) || (cmd_reg == upq_pkg::CMD_UPDATE);
    assign full     = (count_reg == CW'(CAPACITY));
    assign enq_ok   = ctrl.start && (cmd_reg == upq_pkg::CMD_ENQ) && !full;
    assign issue    = (idx_reg < count_reg);
    assign last_pos = count_reg - CW'(1);
    assign hit      = pend_reg && is_find && (rd_key == key_reg);
    assign at_last  = (CW'(cmp_reg) == last_pos);

    assign stat.cmd        = cmd_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.hit        = hit;
    assign stat.scan_done  = pend_reg && (hit || at_last);

    // read port: scan index, or last entry for delete-min
    assign ram_raddr = ctrl.last_rd ? AW'(last_pos) : AW'(idx_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(count_reg);
        ram_wdata = {key_reg, prio_reg};
        if (enq_ok)
        begin
            ram_we = 1'b1;
        end
        else if (ctrl.upd_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = cmp_reg;
        end
        else if (ctrl.move)
        begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_reg;
            ram_wdata = ram_rdata;
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_next       = cmp_reg;
        pend_next      = 1'b0;
        have_best_next = have_best_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        best_prio_next = best_prio_reg;
        found_next     = found_reg;
        res_st_next    = res_st_reg;

        if (ctrl.start)
        begin
            idx_next       = '0;
            have_best_next = 1'b0;
            found_next     = 1'b0;
            unique case (cmd_reg)
                upq_pkg::CMD_ENQ:
                    res_st_next = full ? upq_pkg::ST_FULL : upq_pkg::ST_OK;
                upq_pkg::CMD_DELMIN:
                    res_st_next = (count_reg == '0) ? upq_pkg::ST_EMPTY : upq_pkg::ST_OK;
                upq_pkg::CMD_UPDATE:
                    res_st_next = (count_reg == '0) ? upq_pkg::ST_MISSING : upq_pkg::ST_OK;
                default:
                    res_st_next = upq_pkg::ST_OK;
            endcase
            if (enq_ok)
            begin
                count_next = count_reg + CW'(1);
            end
        end

        if (ctrl.step)
        begin
            if (issue)
            begin
                idx_next  = idx_reg + CW'(1);
                cmp_next  = AW'(idx_reg);
                pend_next = 1'b1;
            end
            // strict less keeps the earliest slot on ties
            if (pend_reg && (cmd_reg == upq_pkg::CMD_DELMIN) &&
                (!have_best_reg || ($signed(rd_prio) < $signed(best_prio_reg))))
            begin
                have_best_next = 1'b1;
                best_idx_next  = cmp_reg;
                best_key_next  = rd_key;
                best_prio_next = rd_prio;
            end
            if (hit)
            begin
                found_next = 1'b1;
            end
            else if (pend_reg && at_last && (cmd_reg == upq_pkg::CMD_UPDATE))
            begin
                res_st_next = upq_pkg::ST_MISSING;
            end
        end

        if (ctrl.move)
        begin
            count_next = last_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            cmd_reg  <= command;
            key_reg  <= item_key;
            prio_reg <= item_priority;
        end
        idx_reg       <= idx_next;
        cmp_reg       <= cmp_next;
        have_best_reg <= have_best_next;
        best_idx_reg  <= best_idx_next;
        best_key_reg  <= best_key_next;
        best_prio_reg <= best_prio_next;
        found_reg     <= found_next;
        res_st_reg    <= res_st_next;
        if (ctrl.load_out)
        begin
            if ((cmd_reg == upq_pkg::CMD_DELMIN) && (res_st_reg == upq_pkg::ST_OK))
            begin
                out_key      <= best_key_reg;
                out_priority <= best_prio_reg;
            end
            else
            begin
                out_key      <= '0;
                out_priority <= '0;
            end
            key_found    <= found_reg;
            status       <= res_st_reg;
            entries_held <= count_reg;
            queue_empty  <= (count_reg == '0);
        end
    end

endmodule

`default_nettype wire

@@ rtl/upq_ctrl.sv @@
`default_nettype none

module upq_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire upq_pkg::upq_stat_t    stat,
    output upq_pkg::upq_ctrl_t         ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LAST   = 3'd3;
    localparam logic [2:0] S_MOVE   = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.accept = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                ctrl.start = 1'b1;
                if ((stat.cmd == upq_pkg::CMD_ENQ) || stat.count_zero)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctrl.step = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.cmd == upq_pkg::CMD_DELMIN)
                    begin
                        state_next = S_LAST;
                    end
                    else
                    begin
                        ctrl.upd_wr = stat.hit && (stat.cmd == upq_pkg::CMD_UPDATE);
                        state_next  = S_RESULT;
                    end
                end
            end
            S_LAST:
            begin
                ctrl.last_rd = 1'b1;
                state_next   = S_MOVE;
            end
            S_MOVE:
            begin
                ctrl.move  = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    ctrl.load_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
